// ===== sv/gmdfs_pkg.sv =====
// ----------------------------------------------------------------------------
// gmdfs_pkg: shared types and microcode for the grid maze path finder
// Request/response payloads, stack entry layout, control word format and the
// read-only microprogram that drives the search datapath.
// ----------------------------------------------------------------------------
package gmdfs_pkg;

   localparam int COORD_W     = 3;
   localparam int DIR_W       = 3;
   localparam int COUNT_W     = 4;
   localparam int CSR_INDEX_W = 1;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_COUNT = 1'b0,
      CSR_COL_COUNT = 1'b1
   } csr_index_type;

   // Move directions, in the order the search tries them
   typedef enum logic [DIR_W-1:0] {
      DIR_NONE  = 3'd0,
      DIR_DOWN  = 3'd1,
      DIR_RIGHT = 3'd2,
      DIR_UP    = 3'd3,
      DIR_LEFT  = 3'd4
   } dir_type;

   typedef struct packed {
      logic               mode;
      logic [COORD_W-1:0] cell_row;
      logic [COORD_W-1:0] cell_col;
      logic               cell_wall;
      logic [COORD_W-1:0] start_row;
      logic [COORD_W-1:0] start_col;
      logic [COORD_W-1:0] exit_row;
      logic [COORD_W-1:0] exit_col;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [COORD_W-1:0] pos_row;
      logic [COORD_W-1:0] pos_col;
      logic [DIR_W-1:0]   step_dir;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [DIR_W-1:0]   dir;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } stack_entry_type;

   // Microprogram addresses
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHK_START,
      ST_MARK,
      ST_TEST,
      ST_DIR_CHK,
      ST_ADVANCE,
      ST_SEED,
      ST_FLOOD,
      ST_DECIDE,
      ST_PUSH,
      ST_POP,
      ST_RELOAD,
      ST_NOT_FOUND,
      ST_EMIT_TOP,
      ST_EMIT_RD,
      ST_EMIT_MEM
   } step_type;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_MARK_TOP,
      OP_STEP_DIR,
      OP_SEED,
      OP_GROW,
      OP_PUSH,
      OP_POP,
      OP_LOAD_TOP,
      OP_EMIT_NF,
      OP_EMIT_TOP,
      OP_READ,
      OP_EMIT_MEM
   } op_type;

   // Branch conditions
   typedef enum logic [3:0] {
      C_NEVER,
      C_NO_SEARCH,
      C_START_OUT,
      C_TOP_IS_EXIT,
      C_DIR_DONE,
      C_NBR_BLOCKED,
      C_FLOOD_BUSY,
      C_EXIT_UNREACHED,
      C_DEPTH_ONE,
      C_OUT_BUSY,
      C_DEPTH_ZERO
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type jump;
      step_type next;
   } ctrl_word_type;

   typedef struct packed {
      logic no_search;
      logic start_out;
      logic top_is_exit;
      logic dir_done;
      logic nbr_blocked;
      logic flood_busy;
      logic exit_unreached;
      logic depth_one;
      logic out_busy;
      logic depth_zero;
   } flags_type;

   function automatic ctrl_word_type cw(input op_type op, input cond_type cond,
                                        input step_type jump, input step_type next);
      ctrl_word_type w;
      w.op   = op;
      w.cond = cond;
      w.jump = jump;
      w.next = next;
      return w;
   endfunction

   // Microprogram: taken branch goes to jump, otherwise to next
   function automatic ctrl_word_type ucode_word(input step_type step);
      ctrl_word_type w;
      w = cw(OP_NONE, C_NEVER, ST_IDLE, ST_IDLE);
      case (step)
         ST_IDLE:      w = cw(OP_ACCEPT,   C_NO_SEARCH,      ST_IDLE,      ST_CHK_START);
         ST_CHK_START: w = cw(OP_NONE,     C_START_OUT,      ST_NOT_FOUND, ST_MARK);
         ST_MARK:      w = cw(OP_MARK_TOP, C_NEVER,          ST_TEST,      ST_TEST);
         ST_TEST:      w = cw(OP_NONE,     C_TOP_IS_EXIT,    ST_EMIT_TOP,  ST_DIR_CHK);
         ST_DIR_CHK:   w = cw(OP_NONE,     C_DIR_DONE,       ST_POP,       ST_ADVANCE);
         ST_ADVANCE:   w = cw(OP_STEP_DIR, C_NEVER,          ST_SEED,      ST_SEED);
         ST_SEED:      w = cw(OP_SEED,     C_NBR_BLOCKED,    ST_DIR_CHK,   ST_FLOOD);
         ST_FLOOD:     w = cw(OP_GROW,     C_FLOOD_BUSY,     ST_FLOOD,     ST_DECIDE);
         ST_DECIDE:    w = cw(OP_NONE,     C_EXIT_UNREACHED, ST_DIR_CHK,   ST_PUSH);
         ST_PUSH:      w = cw(OP_PUSH,     C_NEVER,          ST_TEST,      ST_TEST);
         ST_POP:       w = cw(OP_POP,      C_DEPTH_ONE,      ST_NOT_FOUND, ST_RELOAD);
         ST_RELOAD:    w = cw(OP_LOAD_TOP, C_NEVER,          ST_DIR_CHK,   ST_DIR_CHK);
         ST_NOT_FOUND: w = cw(OP_EMIT_NF,  C_OUT_BUSY,       ST_NOT_FOUND, ST_IDLE);
         ST_EMIT_TOP:  w = cw(OP_EMIT_TOP, C_OUT_BUSY,       ST_EMIT_TOP,  ST_EMIT_RD);
         ST_EMIT_RD:   w = cw(OP_READ,     C_DEPTH_ZERO,     ST_IDLE,      ST_EMIT_MEM);
         ST_EMIT_MEM:  w = cw(OP_EMIT_MEM, C_OUT_BUSY,       ST_EMIT_MEM,  ST_EMIT_RD);
         default:      w = cw(OP_NONE,     C_NEVER,          ST_IDLE,      ST_IDLE);
      endcase
      return w;
   endfunction

endpackage

// ===== sv/gmdfs_sequencer.sv =====
// ----------------------------------------------------------------------------
// gmdfs_sequencer: microcode sequencer for the maze search
// Holds the step counter, fetches the control word from the microprogram and
// picks the next step from the selected branch condition.
// ----------------------------------------------------------------------------
module gmdfs_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  gmdfs_pkg::flags_type     flags,
   output gmdfs_pkg::ctrl_word_type ctrl
);

   gmdfs_pkg::step_type step_ff;
   gmdfs_pkg::step_type step_in;
   logic                cond_hit;

   // Fetch the control word for the current step
   always_comb begin
      ctrl = gmdfs_pkg::ucode_word(step_ff);
   end

   // Select the branch condition and form the next step
   always_comb begin
      case (ctrl.cond)
         gmdfs_pkg::C_NEVER:          cond_hit = 1'b0;
         gmdfs_pkg::C_NO_SEARCH:      cond_hit = flags.no_search;
         gmdfs_pkg::C_START_OUT:      cond_hit = flags.start_out;
         gmdfs_pkg::C_TOP_IS_EXIT:    cond_hit = flags.top_is_exit;
         gmdfs_pkg::C_DIR_DONE:       cond_hit = flags.dir_done;
         gmdfs_pkg::C_NBR_BLOCKED:    cond_hit = flags.nbr_blocked;
         gmdfs_pkg::C_FLOOD_BUSY:     cond_hit = flags.flood_busy;
         gmdfs_pkg::C_EXIT_UNREACHED: cond_hit = flags.exit_unreached;
         gmdfs_pkg::C_DEPTH_ONE:      cond_hit = flags.depth_one;
         gmdfs_pkg::C_OUT_BUSY:       cond_hit = flags.out_busy;
         gmdfs_pkg::C_DEPTH_ZERO:     cond_hit = flags.depth_zero;
         default:                     cond_hit = 1'b0;
      endcase
      step_in = cond_hit ? ctrl.jump : ctrl.next;
   end

   // Advance the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= gmdfs_pkg::ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== sv/grid_maze_dfs_path_finder.sv =====
// Load requests can be accepted back to back while the block is idle.
// A search runs one flood-fill pass per open neighbour tried, and the flood
// fill bounds the search time. Path output emits the exit cell, then reads
// and emits each stack entry below it in turn, back to the entrance.
// Reset clears the maze bitmap and the stack depth and restores both counts
// to 8; no clearing pass follows.
// ----------------------------------------------------------------------------
// grid_maze_dfs_path_finder: depth-first maze search with an explicit stack
// Loads maze cells into a wall bitmap, walks the maze from entrance to exit
// under microcode control and returns the path from exit back to entrance.
// ----------------------------------------------------------------------------
module grid_maze_dfs_path_finder #(
   parameter int MAX_ROWS = 8,
   parameter int MAX_COLS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  gmdfs_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output gmdfs_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gmdfs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gmdfs_pkg::COUNT_W-1:0]        csr_data
);

   localparam int CELLS   = MAX_ROWS * MAX_COLS;
   localparam int CELL_W  = $clog2(CELLS);
   localparam int DEPTH_W = $clog2(CELLS + 1);
   localparam int CW      = gmdfs_pkg::COUNT_W;
   localparam int XW      = gmdfs_pkg::COORD_W;
   localparam int DW      = gmdfs_pkg::DIR_W;
   localparam logic [CW-1:0] MAX_R_CNT = CW'(MAX_ROWS);
   localparam logic [CW-1:0] MAX_C_CNT = CW'(MAX_COLS);
   localparam logic [CW-1:0] CNT_RESET = CW'(8);

   function automatic logic [CELL_W-1:0] cell_idx(input logic [XW-1:0] r,
                                                  input logic [XW-1:0] c);
      int flat;
      flat = int'(r) * MAX_COLS + int'(c);
      return flat[CELL_W-1:0];
   endfunction

   // Control
   gmdfs_pkg::ctrl_word_type ctrl;
   gmdfs_pkg::flags_type     flags;

   // Configuration
   logic [CW-1:0] row_count_ff, row_count_in;
   logic [CW-1:0] col_count_ff, col_count_in;
   logic [CW-1:0] row_lim, col_lim;

   // Maze and flood-fill state
   logic [CELLS-1:0] maze_ff, maze_in;
   logic [CELLS-1:0] reach_ff, reach_in;
   logic [CELLS-1:0] active;
   logic [CELLS-1:0] grow;

   // Top of stack and search target
   logic [XW-1:0]      top_r_ff, top_r_in;
   logic [XW-1:0]      top_c_ff, top_c_in;
   logic [DW-1:0]      top_d_ff, top_d_in;
   logic [XW-1:0]      exit_r_ff, exit_r_in;
   logic [XW-1:0]      exit_c_ff, exit_c_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [DEPTH_W-1:0] depth_m1, depth_m2;

   // Stack memory below the top entry
   gmdfs_pkg::stack_entry_type stack_mem [CELLS];
   gmdfs_pkg::stack_entry_type mem_rd_ff;
   gmdfs_pkg::stack_entry_type mem_wr_data;
   logic                       mem_we, mem_re;
   logic [CELL_W-1:0]          mem_wr_addr, mem_rd_addr;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   gmdfs_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic               out_free;

   // Decoded cell facts
   logic              top_in, exit_in, nbr_in, load_ok, exit_hit;
   logic [XW-1:0]     nbr_r, nbr_c;
   logic [CELL_W-1:0] top_idx, exit_idx, nbr_idx, load_idx;

   gmdfs_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   assign req_ready = (ctrl.op == gmdfs_pkg::OP_ACCEPT);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Saturate counts into 1..MAX
   always_comb begin
      if (row_count_ff == '0) begin
         row_lim = CW'(1);
      end else if (row_count_ff > MAX_R_CNT) begin
         row_lim = MAX_R_CNT;
      end else begin
         row_lim = row_count_ff;
      end
      if (col_count_ff == '0) begin
         col_lim = CW'(1);
      end else if (col_count_ff > MAX_C_CNT) begin
         col_lim = MAX_C_CNT;
      end else begin
         col_lim = col_count_ff;
      end
   end

   // Active-grid mask and one flood-fill growth step over all cells
   for (genvar gr = 0; gr < MAX_ROWS; gr++) begin : g_row
      for (genvar gc = 0; gc < MAX_COLS; gc++) begin : g_col
         localparam int I = gr * MAX_COLS + gc;
         logic up_hit, dn_hit, lf_hit, rt_hit;
         if (gr > 0) begin : g_up
            assign up_hit = reach_ff[I-MAX_COLS];
         end else begin : g_no_up
            assign up_hit = 1'b0;
         end
         if (gr < MAX_ROWS - 1) begin : g_dn
            assign dn_hit = reach_ff[I+MAX_COLS];
         end else begin : g_no_dn
            assign dn_hit = 1'b0;
         end
         if (gc > 0) begin : g_lf
            assign lf_hit = reach_ff[I-1];
         end else begin : g_no_lf
            assign lf_hit = 1'b0;
         end
         if (gc < MAX_COLS - 1) begin : g_rt
            assign rt_hit = reach_ff[I+1];
         end else begin : g_no_rt
            assign rt_hit = 1'b0;
         end
         assign active[I] = (CW'(gr) < row_lim) && (CW'(gc) < col_lim);
         assign grow[I]   = reach_ff[I]
                          | (active[I] & ~maze_ff[I] & (up_hit | dn_hit | lf_hit | rt_hit));
      end
   end

   // Locate top, exit and load cells
   always_comb begin
      top_in   = (CW'(top_r_ff) < row_lim) && (CW'(top_c_ff) < col_lim);
      exit_in  = (CW'(exit_r_ff) < row_lim) && (CW'(exit_c_ff) < col_lim);
      load_ok  = (int'(req_data.cell_row) < MAX_ROWS) && (int'(req_data.cell_col) < MAX_COLS);
      top_idx  = top_in ? cell_idx(top_r_ff, top_c_ff) : '0;
      exit_idx = exit_in ? cell_idx(exit_r_ff, exit_c_ff) : '0;
      load_idx = load_ok ? cell_idx(req_data.cell_row, req_data.cell_col) : '0;
      exit_hit = exit_in && reach_ff[exit_idx];
      depth_m1 = depth_ff - DEPTH_W'(1);
      depth_m2 = depth_ff - DEPTH_W'(2);
   end

   // Neighbor of the top cell in its current direction
   always_comb begin
      nbr_in = 1'b0;
      nbr_r  = top_r_ff;
      nbr_c  = top_c_ff;
      case (top_d_ff)
         gmdfs_pkg::DIR_DOWN: begin
            nbr_in = (CW'(top_r_ff) + CW'(1)) < row_lim;
            nbr_r  = top_r_ff + XW'(1);
         end
         gmdfs_pkg::DIR_RIGHT: begin
            nbr_in = (CW'(top_c_ff) + CW'(1)) < col_lim;
            nbr_c  = top_c_ff + XW'(1);
         end
         gmdfs_pkg::DIR_UP: begin
            nbr_in = (top_r_ff != '0);
            nbr_r  = top_r_ff - XW'(1);
         end
         gmdfs_pkg::DIR_LEFT: begin
            nbr_in = (top_c_ff != '0);
            nbr_c  = top_c_ff - XW'(1);
         end
         default: begin
            nbr_in = 1'b0;
         end
      endcase
      nbr_idx = nbr_in ? cell_idx(nbr_r, nbr_c) : '0;
   end

   // Branch conditions for the sequencer
   always_comb begin
      flags.no_search      = !(req_valid && req_data.mode);
      flags.start_out      = !top_in;
      flags.top_is_exit    = (top_r_ff == exit_r_ff) && (top_c_ff == exit_c_ff);
      flags.dir_done       = (top_d_ff == gmdfs_pkg::DIR_LEFT);
      flags.nbr_blocked    = !nbr_in || maze_ff[nbr_idx];
      flags.flood_busy     = !exit_hit && (grow != reach_ff);
      flags.exit_unreached = !exit_hit;
      flags.depth_one      = (depth_ff == DEPTH_W'(1));
      flags.out_busy       = !out_free;
      flags.depth_zero     = (depth_ff == '0);
   end

   // Configuration writes
   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_valid) begin
         case (csr_index)
            gmdfs_pkg::CSR_ROW_COUNT: row_count_in = csr_data;
            gmdfs_pkg::CSR_COL_COUNT: col_count_in = csr_data;
            default: ;
         endcase
      end
   end

   // Datapath: execute the control word's operation
   always_comb begin
      maze_in      = maze_ff;
      reach_in     = reach_ff;
      top_r_in     = top_r_ff;
      top_c_in     = top_c_ff;
      top_d_in     = top_d_ff;
      exit_r_in    = exit_r_ff;
      exit_c_in    = exit_c_ff;
      depth_in     = depth_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_wr_addr  = depth_m1[CELL_W-1:0];
      mem_rd_addr  = depth_m1[CELL_W-1:0];
      mem_wr_data.dir = top_d_ff;
      mem_wr_data.col = top_c_ff;
      mem_wr_data.row = top_r_ff;
      case (ctrl.op)
         gmdfs_pkg::OP_ACCEPT: begin
            if (req_valid && !req_data.mode) begin
               if (load_ok) begin
                  maze_in[load_idx] = req_data.cell_wall;
               end
            end else if (req_valid) begin
               top_r_in  = req_data.start_row;
               top_c_in  = req_data.start_col;
               top_d_in  = gmdfs_pkg::DIR_NONE;
               exit_r_in = req_data.exit_row;
               exit_c_in = req_data.exit_col;
               depth_in  = DEPTH_W'(1);
            end
         end
         gmdfs_pkg::OP_MARK_TOP: begin
            maze_in[top_idx] = 1'b1;
         end
         gmdfs_pkg::OP_STEP_DIR: begin
            top_d_in = top_d_ff + DW'(1);
         end
         gmdfs_pkg::OP_SEED: begin
            reach_in          = '0;
            reach_in[nbr_idx] = 1'b1;
         end
         gmdfs_pkg::OP_GROW: begin
            reach_in = grow;
         end
         gmdfs_pkg::OP_PUSH: begin
            mem_we           = 1'b1;
            top_r_in         = nbr_r;
            top_c_in         = nbr_c;
            top_d_in         = gmdfs_pkg::DIR_NONE;
            depth_in         = depth_ff + DEPTH_W'(1);
            maze_in[nbr_idx] = 1'b1;
         end
         gmdfs_pkg::OP_POP: begin
            maze_in[top_idx] = 1'b0;
            depth_in         = depth_m1;
            mem_re           = 1'b1;
            mem_rd_addr      = depth_m2[CELL_W-1:0];
         end
         gmdfs_pkg::OP_LOAD_TOP: begin
            top_r_in = mem_rd_ff.row;
            top_c_in = mem_rd_ff.col;
            top_d_in = mem_rd_ff.dir;
         end
         gmdfs_pkg::OP_EMIT_NF: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.found    = 1'b0;
               rsp_data_in.pos_row  = '0;
               rsp_data_in.pos_col  = '0;
               rsp_data_in.step_dir = '0;
               rsp_data_in.last     = 1'b1;
               depth_in             = '0;
            end
         end
         gmdfs_pkg::OP_EMIT_TOP: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.found    = 1'b1;
               rsp_data_in.pos_row  = top_r_ff;
               rsp_data_in.pos_col  = top_c_ff;
               rsp_data_in.step_dir = top_d_ff;
               rsp_data_in.last     = flags.depth_one;
               depth_in             = depth_m1;
            end
         end
         gmdfs_pkg::OP_READ: begin
            mem_re = 1'b1;
         end
         gmdfs_pkg::OP_EMIT_MEM: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.found    = 1'b1;
               rsp_data_in.pos_row  = mem_rd_ff.row;
               rsp_data_in.pos_col  = mem_rd_ff.col;
               rsp_data_in.step_dir = mem_rd_ff.dir;
               rsp_data_in.last     = flags.depth_one;
               depth_in             = depth_m1;
            end
         end
         default: ;
      endcase
   end

   // Stack memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_re) begin
         mem_rd_ff <= stack_mem[mem_rd_addr];
      end
   end

   // Control and maze registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= CNT_RESET;
         col_count_ff <= CNT_RESET;
         maze_ff      <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         maze_ff      <= maze_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      reach_ff    <= reach_in;
      top_r_ff    <= top_r_in;
      top_c_ff    <= top_c_in;
      top_d_ff    <= top_d_in;
      exit_r_ff   <= exit_r_in;
      exit_c_ff   <= exit_c_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The flood fill only ever covers open cells
   a_reach_open: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == gmdfs_pkg::OP_GROW |-> (reach_ff & maze_ff) == '0)
      else $error("flood fill reached a walled cell");

   // The cell on top of the stack is always marked while its neighbors are tried
   a_top_marked: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == gmdfs_pkg::OP_STEP_DIR |-> maze_ff[top_idx])
      else $error("top of stack is not marked in the bitmap");

   // Emitting the exit cell always loads a found response
   a_emit_top: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == gmdfs_pkg::OP_EMIT_TOP && out_free) |=> rsp_valid_ff && rsp_data_ff.found)
      else $error("exit cell response missing");

   // Stack never grows past the number of cells
   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      int'(depth_ff) <= CELLS)
      else $error("stack depth out of range");

endmodule
